// ===== hdl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the position packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

   // Packet layout
   localparam logic [15:0] MIN_PACKET_BYTES      = 16'd4;
   localparam logic [15:0] POSITION_PACKET_BYTES = 16'd24;
   localparam logic [15:0] POSITION_TYPE         = 16'd0;
   localparam logic [15:0] MAX_PACKET_RESET      = 16'd128;

   // Byte offsets inside the packet
   localparam logic [15:0] LEN_LO_OFFSET  = 16'd0;
   localparam logic [15:0] LEN_HI_OFFSET  = 16'd1;
   localparam logic [15:0] TYPE_LO_OFFSET = 16'd2;
   localparam logic [15:0] TYPE_HI_OFFSET = 16'd3;
   localparam int          TIME_OFFSET    = 4;
   localparam int          RA_OFFSET      = 12;
   localparam int          DEC_OFFSET     = 16;
   localparam int          STATUS_OFFSET  = 20;

   // Request command codes
   typedef enum logic {
      CMD_DATA  = 1'b0,
      CMD_RESET = 1'b1
   } ppd_cmd_type;

   // Response report kinds
   typedef enum logic [1:0] {
      KIND_POSITION   = 2'd0,
      KIND_BAD_LENGTH = 2'd1,
      KIND_SHORT      = 2'd2
   } ppd_kind_type;

   // One response record
   typedef struct packed {
      ppd_kind_type kind;
      logic [63:0]  micros;
      logic [31:0]  ra;
      logic [31:0]  dec;
      logic [31:0]  status;
   } ppd_result_type;

   // Front-to-queue push
   typedef struct packed {
      logic           valid;
      ppd_result_type data;
   } ppd_push_type;

endpackage

`default_nettype wire

// ===== hdl/ppd_parser.sv =====
// ----------------------------------------------------------------------------
// ppd_parser
// Front end: accepts request bytes, tracks the packet position and assembles
// the position fields; pushes one response record per reported packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_accept,
   input  wire logic                 command,
   input  wire logic [7:0]           rx_byte,
   input  wire logic [15:0]          max_bytes,
   output ppd_pkg::ppd_push_type     push
);

   logic [15:0] idx_ff, idx_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] type_ff, type_in;
   logic [63:0] time_ff, time_in;
   logic [31:0] ra_ff, ra_in;
   logic [31:0] dec_ff, dec_in;
   logic [31:0] status_ff, status_in;
   logic        halted_ff, halted_in;

   logic [15:0] len_nx, type_nx;
   logic [63:0] time_nx;
   logic [31:0] ra_nx, dec_nx, status_nx;
   logic        bad_len, frame_end;

   // Field assembly for the current byte
   always_comb begin
      len_nx    = len_ff;
      type_nx   = type_ff;
      time_nx   = time_ff;
      ra_nx     = ra_ff;
      dec_nx    = dec_ff;
      status_nx = status_ff;
      if (idx_ff == ppd_pkg::LEN_LO_OFFSET)  len_nx  = {8'h00, rx_byte};
      if (idx_ff == ppd_pkg::LEN_HI_OFFSET)  len_nx  = {rx_byte, len_ff[7:0]};
      if (idx_ff == ppd_pkg::TYPE_LO_OFFSET) type_nx = {8'h00, rx_byte};
      if (idx_ff == ppd_pkg::TYPE_HI_OFFSET) type_nx = {rx_byte, type_ff[7:0]};
      for (int k = 0; k < 8; k++) begin
         if (idx_ff == 16'(ppd_pkg::TIME_OFFSET + k)) time_nx[8*k +: 8] = rx_byte;
      end
      for (int k = 0; k < 4; k++) begin
         if (idx_ff == 16'(ppd_pkg::RA_OFFSET + k))     ra_nx[8*k +: 8]     = rx_byte;
         if (idx_ff == 16'(ppd_pkg::DEC_OFFSET + k))    dec_nx[8*k +: 8]    = rx_byte;
         if (idx_ff == 16'(ppd_pkg::STATUS_OFFSET + k)) status_nx[8*k +: 8] = rx_byte;
      end
   end

   // Length check at the second byte, end of packet at its last byte
   assign bad_len   = (idx_ff == ppd_pkg::LEN_HI_OFFSET) &&
                      ((len_nx < ppd_pkg::MIN_PACKET_BYTES) || (len_nx > max_bytes));
   assign frame_end = (idx_ff >= ppd_pkg::TYPE_HI_OFFSET) &&
                      (({1'b0, idx_ff} + 17'd1) == {1'b0, len_nx});

   // Next state and push
   always_comb begin
      idx_in    = idx_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      time_in   = time_ff;
      ra_in     = ra_ff;
      dec_in    = dec_ff;
      status_in = status_ff;
      halted_in = halted_ff;
      push      = '0;
      if (in_accept) begin
         if (ppd_pkg::ppd_cmd_type'(command) == ppd_pkg::CMD_RESET) begin
            idx_in    = '0;
            len_in    = '0;
            type_in   = '0;
            time_in   = '0;
            ra_in     = '0;
            dec_in    = '0;
            status_in = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            if (bad_len) begin
               len_in          = len_nx;
               idx_in          = '0;
               halted_in       = 1'b1;
               push.valid      = 1'b1;
               push.data.kind  = ppd_pkg::KIND_BAD_LENGTH;
            end else if (frame_end) begin
               idx_in    = '0;
               len_in    = '0;
               type_in   = '0;
               time_in   = '0;
               ra_in     = '0;
               dec_in    = '0;
               status_in = '0;
               if (type_nx == ppd_pkg::POSITION_TYPE) begin
                  push.valid = 1'b1;
                  if (len_nx < ppd_pkg::POSITION_PACKET_BYTES) begin
                     halted_in      = 1'b1;
                     push.data.kind = ppd_pkg::KIND_SHORT;
                  end else begin
                     push.data.kind   = ppd_pkg::KIND_POSITION;
                     push.data.micros = time_nx;
                     push.data.ra     = ra_nx;
                     push.data.dec    = dec_nx;
                     push.data.status = status_nx;
                  end
               end
            end else begin
               idx_in    = idx_ff + 16'd1;
               len_in    = len_nx;
               type_in   = type_nx;
               time_in   = time_nx;
               ra_in     = ra_nx;
               dec_in    = dec_nx;
               status_in = status_nx;
            end
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         len_ff    <= '0;
         type_ff   <= '0;
         time_ff   <= '0;
         ra_ff     <= '0;
         dec_ff    <= '0;
         status_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         len_ff    <= len_in;
         type_ff   <= type_in;
         time_ff   <= time_in;
         ra_ff     <= ra_in;
         dec_ff    <= dec_in;
         status_ff <= status_in;
         halted_ff <= halted_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Error reports leave the parser halted
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.data.kind != ppd_pkg::KIND_POSITION) |=> halted_ff)
      else $error("error report did not halt the parser");

   // A halted parser sits at the start of a packet
   a_halted_idx: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (idx_ff == 16'd0))
      else $error("halted parser with nonzero byte index");

   // Past the length bytes the position stays inside a checked length
   a_idx_in_frame: assert property (@(posedge clock) disable iff (reset)
      (idx_ff > ppd_pkg::LEN_HI_OFFSET) |->
         (len_ff >= ppd_pkg::MIN_PACKET_BYTES && idx_ff < len_ff))
      else $error("byte index outside the packet length");

   // Nothing is reported while halted
   a_no_push_halted: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (in_accept && !halted_ff))
      else $error("report pushed while halted or idle");
`endif

endmodule

`default_nettype wire

// ===== hdl/ppd_queue.sv =====
// ----------------------------------------------------------------------------
// ppd_queue
// Back end: two-entry response queue whose head drives the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ppd_pkg::ppd_push_type  push,
   output logic                        full,
   output logic                        deq_valid,
   input  wire logic                   deq_ready,
   output ppd_pkg::ppd_result_type     deq_data
);

   ppd_pkg::ppd_result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign deq_valid = (count_ff != 2'd0);
   assign deq_data  = mem_ff[rd_ptr_ff];
   assign pop       = deq_valid && deq_ready;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ptr_ff] <= push.data;
   end

`ifndef NO_ASSERTIONS
   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full response queue");

   // Count never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response queue count out of range");

   // Pointers agree with the count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== hdl/position_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// position_packet_deframer
// Deframes length-prefixed packets from a byte stream and reports position
// packets and framing errors.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while req_tready is high: a data byte
// (req_tuser = 0) or a connection reset (req_tuser = 1). Each byte is parsed
// in the cycle it is accepted; a report is pushed into a two-entry response
// queue on the byte that completes the length field (bad length) or the last
// byte of a type-0 packet. req_tready drops only while that queue is full, so
// with the response side ready the rate is one byte per clock and a report
// appears on rsp in the cycle after its last byte. After a length or short-packet
// error data bytes are dropped until a connection reset request. csr_data sets the
// largest accepted packet length (reset value 128); write it while idle.
`default_nettype none

module position_packet_deframer (
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] rx_byte
   input  wire logic          req_tuser,   // [0] command
   // response channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [159:0]       rsp_tdata,   // [63:0] timestamp_us, [95:64] ra_angle,
                                           // [127:96] dec_angle, [159:128] mount_status
   output logic [1:0]         rsp_tuser,   // [1:0] report_kind
   // configuration write
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [15:0]   csr_data     // max_packet_bytes
);

   logic [15:0]             max_bytes_ff, max_bytes_in;
   logic                    in_accept;
   logic                    full;
   ppd_pkg::ppd_push_type   push;
   ppd_pkg::ppd_result_type head;

   // Configuration register
   assign csr_ready    = 1'b1;
   assign max_bytes_in = (csr_valid && csr_ready) ? csr_data : max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) max_bytes_ff <= ppd_pkg::MAX_PACKET_RESET;
      else       max_bytes_ff <= max_bytes_in;
   end

   // Request handshake
   assign req_tready = !full;
   assign in_accept  = req_tvalid && req_tready;

   ppd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .command   (req_tuser),
      .rx_byte   (req_tdata),
      .max_bytes (max_bytes_ff),
      .push      (push)
   );

   ppd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .deq_valid (rsp_tvalid),
      .deq_ready (rsp_tready),
      .deq_data  (head)
   );

   // Response packing
   assign rsp_tuser = 2'(head.kind);
   assign rsp_tdata = {head.status, head.dec, head.ra, head.micros};

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for position_packet_deframer. Byte requests go in on
// req_*, and a predictor built into the bench parses the same bytes. Every
// report on rsp_* is compared field by field with the oldest predicted
// report. The run covers directed framing errors, several settings of the
// length register, random packet streams under sender and receiver idling,
// and a long response stall that fills the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_SHOWN    = 10;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   logic [7:0]    req_tdata  = 8'h00;   // [7:0] rx_byte
   logic          req_tuser  = ppd_pkg::CMD_DATA; // [0] command
   wire           rsp_tvalid;
   logic          rsp_tready = 1'b0;
   wire  [159:0]  rsp_tdata;            // [63:0] micros, [95:64] ra, [127:96] dec,
                                        // [159:128] status
   wire  [1:0]    rsp_tuser;            // [1:0] report_kind
   logic          csr_valid  = 1'b0;
   wire           csr_ready;
   logic [15:0]   csr_data   = 16'h0000; // max_packet_bytes

   position_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Parser copy kept by the bench
   logic [15:0]             max_len;
   logic [15:0]             pos_index;
   logic [15:0]             pkt_len;
   logic [15:0]             pkt_type;
   logic [63:0]             micros_acc;
   logic [31:0]             ra_acc;
   logic [31:0]             dec_acc;
   logic [31:0]             status_acc;
   logic                    parser_halted;
   ppd_pkg::ppd_result_type expected_reports[$];

   // Bookkeeping
   int  mismatch_count  = 0;
   int  requests_taken  = 0;
   int  counted_items   = 0;
   int  kind_seen[3]    = '{0, 0, 0};
   int  send_idle_pct   = 0;
   int  recv_stall_pct  = 0;
   logic hold_active    = 1'b0;
   event hold_start;

   // Drop the packet in progress; the halt flag is left alone
   task automatic restart_frame();
      pos_index  = '0;
      pkt_len    = '0;
      pkt_type   = '0;
      micros_acc = '0;
      ra_acc     = '0;
      dec_acc    = '0;
      status_acc = '0;
   endtask

   // Predict the report (if any) caused by one accepted request
   task automatic parse_request(input ppd_pkg::ppd_cmd_type cmd, input logic [7:0] b);
      ppd_pkg::ppd_result_type rep;
      int idx;
      rep = '0;
      if (cmd == ppd_pkg::CMD_RESET) begin
         restart_frame();
         parser_halted = 1'b0;
         return;
      end
      if (parser_halted) return;
      idx = pos_index;
      if (idx == ppd_pkg::LEN_LO_OFFSET) begin
         pkt_len = {8'h00, b};
      end else if (idx == ppd_pkg::LEN_HI_OFFSET) begin
         pkt_len[15:8] = b;
         if (pkt_len < ppd_pkg::MIN_PACKET_BYTES || pkt_len > max_len) begin
            parser_halted = 1'b1;
            pos_index = '0;
            rep.kind = ppd_pkg::KIND_BAD_LENGTH;
            expected_reports.push_back(rep);
            return;
         end
      end else if (idx == ppd_pkg::TYPE_LO_OFFSET) begin
         pkt_type = {8'h00, b};
      end else if (idx == ppd_pkg::TYPE_HI_OFFSET) begin
         pkt_type[15:8] = b;
      end else if (idx < ppd_pkg::RA_OFFSET) begin
         micros_acc |= 64'(b) << (8 * (idx - ppd_pkg::TIME_OFFSET));
      end else if (idx < ppd_pkg::DEC_OFFSET) begin
         ra_acc |= 32'(b) << (8 * (idx - ppd_pkg::RA_OFFSET));
      end else if (idx < ppd_pkg::STATUS_OFFSET) begin
         dec_acc |= 32'(b) << (8 * (idx - ppd_pkg::DEC_OFFSET));
      end else if (idx < ppd_pkg::POSITION_PACKET_BYTES) begin
         status_acc |= 32'(b) << (8 * (idx - ppd_pkg::STATUS_OFFSET));
      end

      // last byte of the packet
      if (idx >= ppd_pkg::TYPE_HI_OFFSET && idx + 1 == pkt_len) begin
         if (pkt_type == ppd_pkg::POSITION_TYPE) begin
            if (pkt_len < ppd_pkg::POSITION_PACKET_BYTES) begin
               parser_halted = 1'b1;
               rep.kind = ppd_pkg::KIND_SHORT;
            end else begin
               rep.kind   = ppd_pkg::KIND_POSITION;
               rep.micros = micros_acc;
               rep.ra     = ra_acc;
               rep.dec    = dec_acc;
               rep.status = status_acc;
            end
            expected_reports.push_back(rep);
         end
         restart_frame();
         return;
      end
      pos_index = 16'(idx + 1);
   endtask

   // Compare one accepted response with the oldest prediction
   task automatic check_report();
      ppd_pkg::ppd_result_type seen, want;
      seen.kind   = ppd_pkg::ppd_kind_type'(rsp_tuser);
      seen.micros = rsp_tdata[63:0];
      seen.ra     = rsp_tdata[95:64];
      seen.dec    = rsp_tdata[127:96];
      seen.status = rsp_tdata[159:128];
      if (expected_reports.size() == 0) begin
         if (mismatch_count < MAX_SHOWN)
            $display("ERROR: unexpected report kind %0d at %0t", seen.kind, $realtime);
         mismatch_count++;
         return;
      end
      want = expected_reports.pop_front();
      if (seen.kind !== want.kind || seen.micros !== want.micros || seen.ra !== want.ra ||
          seen.dec !== want.dec || seen.status !== want.status) begin
         if (mismatch_count < MAX_SHOWN) begin
            $display("ERROR: report mismatch at %0t", $realtime);
            $display("  expected kind %0d micros %h ra %h dec %h status %h",
                     want.kind, want.micros, want.ra, want.dec, want.status);
            $display("  actual   kind %0d micros %h ra %h dec %h status %h",
                     seen.kind, seen.micros, seen.ra, seen.dec, seen.status);
         end
         mismatch_count++;
      end else if (want.kind <= ppd_pkg::KIND_SHORT) begin
         kind_seen[want.kind]++;
      end
   endtask

   // Monitor: register writes, requests and responses at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         max_len = ppd_pkg::MAX_PACKET_RESET;
         restart_frame();
         parser_halted = 1'b0;
      end else begin
         if (csr_valid && csr_ready) max_len = csr_data;
         if (req_tvalid && req_tready) begin
            parse_request(ppd_pkg::ppd_cmd_type'(req_tuser), req_tdata);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_report();
      end
   end

   // Response side: random stalls, or a long hold-off when asked
   always @(negedge clock)
      rsp_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);

   // Long hold-off, counted in cycles
   always begin
      @(hold_start);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   // Send one request; called and returns at a falling edge
   task automatic send_item(input ppd_pkg::ppd_cmd_type cmd, input logic [7:0] b);
      if (cmd == ppd_pkg::CMD_RESET || !parser_halted) counted_items++;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Send a packet: length, type, then payload; cut > 0 stops early
   task automatic send_frame(input logic [15:0] len, input logic [15:0] ftype,
                             input int fill, input int cut);
      int stop;
      logic [7:0] b;
      stop = (cut > 0) ? cut : int'(len);
      for (int i = 0; i < stop; i++) begin
         // a bad length halts the parser after its second byte
         if (i == 2 && (len < ppd_pkg::MIN_PACKET_BYTES || len > max_len)) return;
         case (i)
            0:       b = len[7:0];
            1:       b = len[15:8];
            2:       b = ftype[7:0];
            3:       b = ftype[15:8];
            default: b = (fill < 0) ? 8'($urandom) : 8'(fill);
         endcase
         send_item(ppd_pkg::CMD_DATA, b);
      end
   endtask

   task automatic send_clear();
      send_item(ppd_pkg::CMD_RESET, 8'($urandom));
   endtask

   // Drop valid and wait until every predicted report has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_len(input logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Framing errors, halted parser and silent skip at the reset setting
   task automatic test_directed_frames();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_clear();
      send_frame(16'd3, ppd_pkg::POSITION_TYPE, -1, 0);      // length below minimum
      send_item(ppd_pkg::CMD_DATA, 8'hFF);                   // ignored while halted
      send_clear();
      send_frame(16'hFFFF, ppd_pkg::POSITION_TYPE, -1, 0);   // length above limit
      send_clear();
      // short position packet
      send_frame(ppd_pkg::MIN_PACKET_BYTES, ppd_pkg::POSITION_TYPE, -1, 0);
      send_clear();
      send_frame(16'd5, 16'hFFFF, 8'hFF, 0);                 // unknown type, skipped
      wait_idle();
   endtask

   // Length register at its extremes and a few settings in between
   task automatic test_length_register();
      write_max_len(16'd0);                                  // every length is bad
      send_frame(ppd_pkg::MIN_PACKET_BYTES, 16'd1, -1, 0);
      send_clear();
      send_frame(16'd0, ppd_pkg::POSITION_TYPE, -1, 0);
      send_clear();

      write_max_len(ppd_pkg::MIN_PACKET_BYTES);
      send_frame(ppd_pkg::MIN_PACKET_BYTES, ppd_pkg::POSITION_TYPE, -1, 0);
      send_clear();
      send_frame(ppd_pkg::MIN_PACKET_BYTES, 16'h8001, -1, 0);
      send_frame(16'd5, 16'h0100, -1, 0);
      send_clear();

      write_max_len(ppd_pkg::POSITION_PACKET_BYTES);
      // all-ones fields
      send_frame(ppd_pkg::POSITION_PACKET_BYTES, ppd_pkg::POSITION_TYPE, 8'hFF, 0);
      send_frame(16'd25, ppd_pkg::POSITION_TYPE, -1, 0);
      send_clear();

      write_max_len(16'hFFFF);
      send_frame(16'hFFFF, ppd_pkg::POSITION_TYPE, -1, 12);  // cut short by a clear
      send_clear();
      send_frame(ppd_pkg::POSITION_PACKET_BYTES, ppd_pkg::POSITION_TYPE, 8'h00, 0);

      write_max_len(ppd_pkg::MAX_PACKET_RESET);
      // long tail skipped
      send_frame(ppd_pkg::MAX_PACKET_RESET, ppd_pkg::POSITION_TYPE, -1, 0);
      send_frame(16'd129, 16'h0002, -1, 0);
      send_clear();
      wait_idle();
   endtask

   // Random packet stream: mostly well-formed, some errors and noise
   task automatic run_random_phase(input int target, input int idle_pct, input int stall_pct,
                                   input logic [15:0] limit);
      int start, choice, cap, lim, len;
      write_max_len(limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      lim   = limit;
      cap   = (lim < 48) ? lim : 48;
      start = counted_items;
      while (counted_items - start < target) begin
         choice = $urandom_range(0, 99);
         if (choice < 55 && cap >= 24) begin
            send_frame(16'($urandom_range(24, cap)), ppd_pkg::POSITION_TYPE, -1, 0);
         end else if (choice < 65) begin
            send_frame(16'($urandom_range(4, (cap < 23) ? cap : 23)),
                       ppd_pkg::POSITION_TYPE, -1, 0);
         end else if (choice < 80) begin
            send_frame(16'($urandom_range(4, cap)), 16'($urandom_range(1, 65535)), -1, 0);
         end else if (choice < 84) begin
            // an occasional long position packet
            send_frame(16'($urandom_range(24, (lim < 300) ? lim : 300)),
                       ppd_pkg::POSITION_TYPE, -1, 0);
         end else if (choice < 91) begin
            if (lim < 65535 && $urandom_range(0, 1) == 1)
               len = $urandom_range(lim + 1, 65535);
            else
               len = $urandom_range(0, ppd_pkg::MIN_PACKET_BYTES - 1);
            send_frame(16'(len), 16'($urandom), -1, 0);
         end else if (choice < 96) begin
            // packet broken off by a connection reset
            len = $urandom_range(5, cap);
            send_frame(16'(len),
                       ($urandom_range(0, 1) == 1) ? ppd_pkg::POSITION_TYPE : 16'($urandom),
                       -1, $urandom_range(1, len - 1));
            send_clear();
         end else begin
            send_clear();
         end
         if (parser_halted) begin
            repeat ($urandom_range(0, 3)) send_item(ppd_pkg::CMD_DATA, 8'($urandom));
            send_clear();
         end
      end
      wait_idle();
   endtask

   // Hold the response side off while position packets keep coming
   task automatic test_backpressure();
      write_max_len(ppd_pkg::MAX_PACKET_RESET);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      -> hold_start;
      repeat (6) send_frame(16'($urandom_range(24, 32)), ppd_pkg::POSITION_TYPE, -1, 0);
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_length_register();
      run_random_phase(260, 0, 0, ppd_pkg::MAX_PACKET_RESET);
      run_random_phase(260, 61, 0, 16'hFFFF);
      run_random_phase(260, 0, 61, 16'd30);
      run_random_phase(260, 28, 28, 16'($urandom_range(24, 400)));
      test_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Summary: %0d requests accepted, %0d mismatches", requests_taken,
               mismatch_count);
      $display("Summary: reports matched: %0d position, %0d bad length, %0d short",
               kind_seen[ppd_pkg::KIND_POSITION], kind_seen[ppd_pkg::KIND_BAD_LENGTH],
               kind_seen[ppd_pkg::KIND_SHORT]);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("ERROR: run timed out with %0d reports outstanding", expected_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// ===== position_packet_deframer.f =====
hdl/ppd_pkg.sv
hdl/ppd_parser.sv
hdl/ppd_queue.sv
hdl/position_packet_deframer.sv
dv/testbench.sv
